@@ hw/rtl/hsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Heater session controller package
// Shared types, codes and constants for the session controller blocks.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int TEMP_WIDTH = 12;
  localparam int TEMP_MAX   = 2**TEMP_WIDTH - 1;

  // raw sample limit, 1000 degrees in q4
  localparam logic [13:0] RAW_MAX_Q4 = 14'd16000;

  // divide by 16*4096*100 = 2^18 * 25
  localparam int          DIV_SHIFT  = 18;
  localparam int          DIV_ODD    = 25;
  localparam logic [40:0] ROUND_HALF = 41'd3276800;
  localparam int          SAT_Q1     = (TEMP_MAX + 1) * DIV_ODD;
  localparam int          Q1_W       = $clog2(SAT_Q1);
  localparam int          RECIP_SH   = 24;
  localparam logic [19:0] RECIP_ODD  = 20'd671089;   // ceil(2^24 / 25)
  localparam int          PROD_W     = Q1_W + 20;

  // front/back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic [2:0] CFG_IR_PCT       = 3'd0;
  localparam logic [2:0] CFG_CAL_SLOPE    = 3'd1;
  localparam logic [2:0] CFG_CAL_OFFSET   = 3'd2;
  localparam logic [2:0] CFG_MIN_HEAT     = 3'd3;
  localparam logic [2:0] CFG_MIN_PEAK     = 3'd4;
  localparam logic [2:0] CFG_DROP_THRESH  = 3'd5;
  localparam logic [2:0] CFG_PAUSE_TMO    = 3'd6;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_PAUSE = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_HEAT  = 2'd1,
    ST_PAUSE = 2'd2
  } session_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_RESUME  = 3'd2,
    EV_PAUSE   = 3'd3,
    EV_REMOVED = 3'd4,
    EV_STOP    = 3'd5,
    EV_TIMEOUT = 3'd6
  } event_t;

  typedef struct packed {
    logic [7:0]  ir_correction_pct;
    logic [15:0] cal_slope_q12;
    logic [14:0] cal_offset_q4;
    logic [19:0] min_heat_ms;
    logic [11:0] min_peak;
    logic [11:0] drop_threshold;
    logic [21:0] pause_timeout_ms;
  } hsc_cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] now_ms;
    logic        take;
    logic [13:0] raw_q4;
    logic [9:0]  raw_deg;
    logic        fault;
  } hsc_item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

@@ hw/rtl/heater_session_controller.sv @@
// ----------------------------------------------------------------------------
// Heater session controller
// Idle/heating/paused session control with IR temperature correction.
//
// Input channel (in_*): one transfer per tick or command (start, pause, stop).
// Each input transfer produces exactly one result transfer on out_*.
// Config channel (cfg_*): cfg_ready is always high; cfg_index selects the
// register, cfg_data carries the value, index 7 is ignored. Write only while
// no transfer is in flight.
// Path from input to result: the queue, the back end item register, then for a
// tick with an in-range sample the two multiply steps and the divide-by-constant
// step (S_MUL1, S_MUL2, S_DIV), then S_APPLY and the result register. The back
// end sequencer takes a new item only after S_APPLY is through with the last.
// A two-entry queue sits between front and back; in_stall rises when it fills.
// When out_stall is high the result register holds and the back end waits,
// the queue absorbs up to two more input transfers.
// Reset: session idle, temperatures and timestamps zero, registers at defaults.
// ----------------------------------------------------------------------------
module heater_session_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_now_ms,
  input  logic        in_sample_valid,
  input  logic [13:0] in_raw_ir_q4,
  input  logic        in_safety_fault,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_session_state,
  output logic        out_heater_on,
  output logic [2:0]  out_event_res,
  output logic [11:0] out_temperature,
  output logic [9:0]  out_raw_temperature,
  output logic [11:0] out_peak_temperature,
  output logic [31:0] out_heating_elapsed_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data
);
  import hsc_pkg::*;

  hsc_cfg_t  cfg_r, cfg_nxt;
  q_stat_t   q_stat;
  hsc_item_t push_item, pop_item;
  logic      q_push, q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_IR_PCT:      cfg_nxt.ir_correction_pct = cfg_data[7:0];
        CFG_CAL_SLOPE:   cfg_nxt.cal_slope_q12     = cfg_data[15:0];
        CFG_CAL_OFFSET:  cfg_nxt.cal_offset_q4     = cfg_data[14:0];
        CFG_MIN_HEAT:    cfg_nxt.min_heat_ms       = cfg_data[19:0];
        CFG_MIN_PEAK:    cfg_nxt.min_peak          = cfg_data[11:0];
        CFG_DROP_THRESH: cfg_nxt.drop_threshold    = cfg_data[11:0];
        CFG_PAUSE_TMO:   cfg_nxt.pause_timeout_ms  = cfg_data[21:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ir_correction_pct <= '0;
      cfg_r.cal_slope_q12     <= 16'd4096;
      cfg_r.cal_offset_q4     <= '0;
      cfg_r.min_heat_ms       <= 20'd5000;
      cfg_r.min_peak          <= 12'd100;
      cfg_r.drop_threshold    <= 12'd5;
      cfg_r.pause_timeout_ms  <= 22'd60000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hsc_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_now_ms       (in_now_ms),
    .in_sample_valid (in_sample_valid),
    .in_raw_ir_q4    (in_raw_ir_q4),
    .in_safety_fault (in_safety_fault),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  hsc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (push_item),
    .pop     (q_pop),
    .rd_item (pop_item),
    .stat    (q_stat)
  );

  hsc_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .q_stat                 (q_stat),
    .q_item                 (pop_item),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_session_state      (out_session_state),
    .out_heater_on          (out_heater_on),
    .out_event_res          (out_event_res),
    .out_temperature        (out_temperature),
    .out_raw_temperature    (out_raw_temperature),
    .out_peak_temperature   (out_peak_temperature),
    .out_heating_elapsed_ms (out_heating_elapsed_ms)
  );

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QDEPTH) && !(q_push && q_stat.full))
    else $error("queue overflow");

  a_heater_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heater_on == (out_session_state == ST_HEAT)) &&
                  (out_heater_on || out_heating_elapsed_ms == 32'd0))
    else $error("heater enable or elapsed time inconsistent with state");

  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_REMOVED || out_event_res == EV_STOP ||
                  out_event_res == EV_TIMEOUT) |-> out_session_state == ST_IDLE)
    else $error("finalize event without idle state");

  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_START || out_event_res == EV_RESUME) |->
      out_peak_temperature == 12'd0 && out_heating_elapsed_ms == 32'd0 &&
      out_session_state == ST_HEAT)
    else $error("start did not clear peak and elapsed time");
`endif

endmodule

@@ hw/rtl/hsc_front.sv @@
// ----------------------------------------------------------------------------
// Heater session controller front end
// Accepts input transfers, decodes the command and qualifies the IR sample.
// ----------------------------------------------------------------------------
module hsc_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [31:0]        in_now_ms,
  input  logic               in_sample_valid,
  input  logic [13:0]        in_raw_ir_q4,
  input  logic               in_safety_fault,
  input  hsc_pkg::q_stat_t   q_stat,
  output logic               q_push,
  output hsc_pkg::hsc_item_t q_item
);
  import hsc_pkg::*;

  logic [14:0] raw_rnd;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;
  assign raw_rnd  = {1'b0, in_raw_ir_q4} + 15'd8;

  always_comb begin
    q_item.cmd     = cmd_t'(in_mode);
    q_item.now_ms  = in_now_ms;
    q_item.take    = (cmd_t'(in_mode) == CMD_TICK) && in_sample_valid &&
                     (in_raw_ir_q4 <= RAW_MAX_Q4);
    q_item.raw_q4  = in_raw_ir_q4;
    q_item.raw_deg = raw_rnd[13:4];
    q_item.fault   = in_safety_fault;
  end

endmodule

@@ hw/rtl/hsc_queue.sv @@
// ----------------------------------------------------------------------------
// Heater session controller queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module hsc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hsc_pkg::hsc_item_t wr_item,
  input  logic               pop,
  output hsc_pkg::hsc_item_t rd_item,
  output hsc_pkg::q_stat_t   stat
);
  import hsc_pkg::*;

  hsc_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign do_push = push && (cnt_r != QCNT_W'(QDEPTH));
  assign do_pop  = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item    = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;

endmodule

@@ hw/rtl/hsc_back.sv @@
// ----------------------------------------------------------------------------
// Heater session controller back end
// Sample correction sequencer, session state machine and result register.
// ----------------------------------------------------------------------------
module hsc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  hsc_pkg::hsc_cfg_t  cfg,
  input  hsc_pkg::q_stat_t   q_stat,
  input  hsc_pkg::hsc_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_session_state,
  output logic               out_heater_on,
  output logic [2:0]         out_event_res,
  output logic [11:0]        out_temperature,
  output logic [9:0]         out_raw_temperature,
  output logic [11:0]        out_peak_temperature,
  output logic [31:0]        out_heating_elapsed_ms
);
  import hsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_APPLY
  } bstate_t;

  bstate_t                 state_r, state_nxt;
  hsc_item_t               item_r, item_nxt;
  logic signed [23:0]      p1_r, p1_nxt;
  logic [19:0]             offm_r, offm_nxt;
  logic signed [40:0]      n_r, n_nxt;
  logic                    neg_r, neg_nxt;
  logic                    sat_r, sat_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;

  session_t                session_r, session_nxt;
  logic [TEMP_WIDTH-1:0]   cur_temp_r, cur_temp_nxt;
  logic [9:0]              raw_temp_r, raw_temp_nxt;
  logic [TEMP_WIDTH-1:0]   peak_r, peak_nxt;
  logic [31:0]             heat_start_r, heat_start_nxt;
  logic [31:0]             pause_start_r, pause_start_nxt;

  logic                    ov_r, ov_nxt;
  logic [1:0]              o_state_r, o_state_nxt;
  logic                    o_heat_r, o_heat_nxt;
  logic [2:0]              o_ev_r, o_ev_nxt;
  logic [11:0]             o_temp_r, o_temp_nxt;
  logic [9:0]              o_raw_r, o_raw_nxt;
  logic [11:0]             o_peak_r, o_peak_nxt;
  logic [31:0]             o_elap_r, o_elap_nxt;

  logic signed [8:0]       fac;
  logic [19:0]             offx;
  logic [TEMP_WIDTH-1:0]   t_corr, t_new, peak_max;
  logic [9:0]              raw_new;
  logic [31:0]             heat_el, pause_el;
  logic                    drop, tmo;
  event_t                  ev;

  assign fac  = $signed({cfg.ir_correction_pct[7], cfg.ir_correction_pct}) + 9'sd100;
  assign offx = {{5{cfg.cal_offset_q4[14]}}, cfg.cal_offset_q4};

  assign t_corr   = neg_r ? '0 :
                    sat_r ? TEMP_WIDTH'(TEMP_MAX) : prod_r[RECIP_SH +: TEMP_WIDTH];
  assign t_new    = item_r.take ? t_corr : cur_temp_r;
  assign raw_new  = item_r.take ? item_r.raw_deg : raw_temp_r;
  assign peak_max = (t_new > peak_r) ? t_new : peak_r;
  assign heat_el  = item_r.now_ms - heat_start_r;
  assign pause_el = item_r.now_ms - pause_start_r;
  assign drop     = (heat_el >= {12'd0, cfg.min_heat_ms}) &&
                    (peak_max >= cfg.min_peak) &&
                    (cfg.drop_threshold <= peak_max) &&
                    (t_new <= peak_max - cfg.drop_threshold);
  assign tmo      = pause_el >= {10'd0, cfg.pause_timeout_ms};

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    p1_nxt          = p1_r;
    offm_nxt        = offm_r;
    n_nxt           = n_r;
    neg_nxt         = neg_r;
    sat_nxt         = sat_r;
    prod_nxt        = prod_r;
    session_nxt     = session_r;
    cur_temp_nxt    = cur_temp_r;
    raw_temp_nxt    = raw_temp_r;
    peak_nxt        = peak_r;
    heat_start_nxt  = heat_start_r;
    pause_start_nxt = pause_start_r;
    ov_nxt          = ov_r;
    o_state_nxt     = o_state_r;
    o_heat_nxt      = o_heat_r;
    o_ev_nxt        = o_ev_r;
    o_temp_nxt      = o_temp_r;
    o_raw_nxt       = o_raw_r;
    o_peak_nxt      = o_peak_r;
    o_elap_nxt      = o_elap_r;
    q_pop           = 1'b0;
    ev              = EV_NONE;

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          state_nxt = q_item.take ? S_MUL1 : S_APPLY;
        end
      end
      S_MUL1: begin
        p1_nxt    = $signed({1'b0, item_r.raw_q4}) * fac;
        offm_nxt  = (offx << 4) + (offx << 3) + offx;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        n_nxt     = p1_r * $signed({1'b0, cfg.cal_slope_q12}) +
                    $signed({{7{offm_r[19]}}, offm_r, 14'd0}) + $signed(ROUND_HALF);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        neg_nxt   = n_r[40];
        sat_nxt   = n_r[39:DIV_SHIFT] >= (40 - DIV_SHIFT)'(SAT_Q1);
        prod_nxt  = n_r[DIV_SHIFT +: Q1_W] * RECIP_ODD;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (!ov_r || !out_stall) begin
          cur_temp_nxt = t_new;
          raw_temp_nxt = raw_new;
          case (item_r.cmd)
            CMD_TICK: begin
              if (session_r == ST_HEAT) begin
                if (item_r.fault) begin
                  session_nxt     = ST_PAUSE;
                  pause_start_nxt = item_r.now_ms;
                  ev              = EV_PAUSE;
                end else begin
                  peak_nxt = peak_max;
                  if (drop) begin
                    session_nxt = ST_IDLE;
                    ev          = EV_REMOVED;
                  end
                end
              end else if (session_r == ST_PAUSE && tmo) begin
                session_nxt = ST_IDLE;
                ev          = EV_TIMEOUT;
              end
            end
            CMD_START: begin
              if (session_r != ST_HEAT) begin
                ev             = (session_r == ST_PAUSE) ? EV_RESUME : EV_START;
                session_nxt    = ST_HEAT;
                peak_nxt       = '0;
                heat_start_nxt = item_r.now_ms;
              end
            end
            CMD_PAUSE: begin
              if (session_r == ST_HEAT) begin
                session_nxt     = ST_PAUSE;
                pause_start_nxt = item_r.now_ms;
                ev              = EV_PAUSE;
              end
            end
            CMD_STOP: begin
              if (session_r == ST_HEAT) begin
                session_nxt = ST_IDLE;
                ev          = EV_STOP;
              end
            end
            default: begin
            end
          endcase
          ov_nxt      = 1'b1;
          o_state_nxt = session_nxt;
          o_heat_nxt  = (session_nxt == ST_HEAT);
          o_ev_nxt    = ev;
          o_temp_nxt  = 12'(cur_temp_nxt);
          o_raw_nxt   = raw_temp_nxt;
          o_peak_nxt  = 12'(peak_nxt);
          o_elap_nxt  = (session_nxt == ST_HEAT) ? item_r.now_ms - heat_start_nxt : '0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      session_r     <= ST_IDLE;
      cur_temp_r    <= '0;
      raw_temp_r    <= '0;
      peak_r        <= '0;
      heat_start_r  <= '0;
      pause_start_r <= '0;
      ov_r          <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      item_r        <= item_nxt;
      p1_r          <= p1_nxt;
      offm_r        <= offm_nxt;
      n_r           <= n_nxt;
      neg_r         <= neg_nxt;
      sat_r         <= sat_nxt;
      prod_r        <= prod_nxt;
      session_r     <= session_nxt;
      cur_temp_r    <= cur_temp_nxt;
      raw_temp_r    <= raw_temp_nxt;
      peak_r        <= peak_nxt;
      heat_start_r  <= heat_start_nxt;
      pause_start_r <= pause_start_nxt;
      ov_r          <= ov_nxt;
      o_state_r     <= o_state_nxt;
      o_heat_r      <= o_heat_nxt;
      o_ev_r        <= o_ev_nxt;
      o_temp_r      <= o_temp_nxt;
      o_raw_r       <= o_raw_nxt;
      o_peak_r      <= o_peak_nxt;
      o_elap_r      <= o_elap_nxt;
    end
  end

  assign out_valid              = ov_r;
  assign out_session_state      = o_state_r;
  assign out_heater_on          = o_heat_r;
  assign out_event_res          = o_ev_r;
  assign out_temperature        = o_temp_r;
  assign out_raw_temperature    = o_raw_r;
  assign out_peak_temperature   = o_peak_r;
  assign out_heating_elapsed_ms = o_elap_r;

endmodule
